// ===== rtl/tss_pkg.sv =====
`timescale 1ns / 1ps

package tss_pkg;

	localparam int unsigned TEXTURE_WORDS = 16384;
	localparam int unsigned SPAN_PIXELS = 8;
	localparam int TEX_AW = $clog2(TEXTURE_WORDS);
	localparam int CNT_W = $clog2(SPAN_PIXELS);
	localparam int IDX_W = 14;

	localparam logic [IDX_W-1:0] UMASK_64 = 14'h003F;
	localparam logic [IDX_W-1:0] UMASK_128 = 14'h007F;
	localparam logic [IDX_W-1:0] VMASK_64 = 14'h0FC0;
	localparam logic [IDX_W-1:0] VMASK_128 = 14'h3F80;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_DRAW = 1'b1
	} op_t;

	typedef enum logic {
		SIZE_64 = 1'b0,
		SIZE_128 = 1'b1
	} size_mode_t;

	typedef struct packed {
		op_t op;
		logic [13:0] texel_address;
		logic [31:0] texel_data;
		logic [19:0] dest_offset;
		logic signed [31:0] u_start;
		logic signed [31:0] v_start;
		logic signed [31:0] u_step;
		logic signed [31:0] v_step;
		logic [7:0] shade;
		logic transparent;
	} req_t;

	typedef struct packed {
		logic [19:0] pixel_address;
		logic [31:0] color;
		logic write_enable;
		logic last;
	} pix_t;

	typedef struct packed {
		logic load;
		logic [IDX_W-1:0] addr;
		logic in_range;
		logic [31:0] wdata;
		logic [19:0] pixel_address;
		logic [7:0] shade;
		logic transparent;
		logic last;
	} s1_t;

	typedef struct packed {
		logic in_range;
		logic [19:0] pixel_address;
		logic [7:0] shade;
		logic transparent;
		logic last;
	} s2_t;

endpackage

// ===== rtl/tss_if.sv =====
`timescale 1ns / 1ps

interface tss_req_if;
	logic valid;
	logic ready;
	tss_pkg::req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tss_pix_if;
	logic valid;
	logic ready;
	tss_pkg::pix_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/textured_span_shader.sv =====
`timescale 1ns / 1ps
// A draw request yields eight pixels on consecutive cycles unless the output stalls; its first
// pixel passes the walker, texture read and shading stages after the request is accepted.
// Unless stalled, the walker emits one pixel per cycle and takes requests back to back.
// Output stalls hold every stage in place without loss or repetition.
// Reset clears all valid bits and sets the 128-wide texture mode; texture memory is not cleared.

module textured_span_shader (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	tss_req_if.sink request,
	tss_pix_if.source pixel
);
	import tss_pkg::*;

	logic en;
	logic valid_s1;
	s1_t s1;
	logic valid_s2;
	s2_t s2;
	logic [31:0] texel_s2;

	tss_span_walker u_walker (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.request(request),
		.valid_s1(valid_s1),
		.s1(s1)
	);

	tss_texel_fetch u_fetch (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_s1(valid_s1),
		.s1(s1),
		.valid_s2(valid_s2),
		.s2(s2),
		.texel_s2(texel_s2)
	);

	tss_shader u_shader (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s2(valid_s2),
		.s2(s2),
		.texel_s2(texel_s2),
		.en(en),
		.pixel(pixel)
	);

endmodule

// ===== rtl/tss_span_walker.sv =====
`timescale 1ns / 1ps

module tss_span_walker (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic cfg_we,
	input logic cfg_wdata,
	tss_req_if.sink request,
	output logic valid_s1,
	output tss_pkg::s1_t s1
);
	import tss_pkg::*;

	size_mode_t mode_q;
	logic busy_q;
	logic load_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] u_q;
	logic [31:0] v_q;
	logic [31:0] ustep_q;
	logic [31:0] vstep_q;
	logic [19:0] dest_q;
	logic [7:0] shade_q;
	logic transp_q;
	logic [13:0] taddr_q;
	logic [31:0] tdata_q;

	logic done;
	logic take;
	logic [IDX_W-1:0] uidx;
	logic [IDX_W-1:0] vidx;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] addr;

	assign done = load_q || (cnt_q == CNT_W'(SPAN_PIXELS - 1));
	assign request.ready = en && (!busy_q || done);
	assign take = request.valid && request.ready;

	always_comb begin
		if (mode_q == SIZE_128) begin
			uidx = u_q[IDX_W+6:7] & UMASK_128;
			vidx = v_q[IDX_W-1:0] & VMASK_128;
		end else begin
			uidx = u_q[IDX_W+5:6] & UMASK_64;
			vidx = v_q[IDX_W-1:0] & VMASK_64;
		end
		idx = uidx + vidx;
		addr = load_q ? taddr_q : idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= SIZE_128;
			busy_q <= 1'b0;
			load_q <= 1'b0;
			cnt_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= size_mode_t'(cfg_wdata);
			end
			if (en) begin
				valid_s1 <= busy_q;
				if (busy_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (done) begin
						busy_q <= 1'b0;
					end
				end
				if (take) begin
					busy_q <= 1'b1;
					load_q <= (request.data.op == OP_LOAD);
					cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1.load <= load_q;
			s1.addr <= addr;
			s1.in_range <= 32'(addr) < TEXTURE_WORDS;
			s1.wdata <= tdata_q;
			s1.pixel_address <= dest_q;
			s1.shade <= shade_q;
			s1.transparent <= transp_q;
			s1.last <= !load_q && done;
			u_q <= u_q + ustep_q;
			v_q <= v_q + vstep_q;
			dest_q <= dest_q + 20'd1;
			if (take) begin
				u_q <= request.data.u_start;
				v_q <= request.data.v_start;
				ustep_q <= request.data.u_step;
				vstep_q <= request.data.v_step;
				dest_q <= request.data.dest_offset;
				shade_q <= request.data.shade;
				transp_q <= request.data.transparent;
				taddr_q <= request.data.texel_address;
				tdata_q <= request.data.texel_data;
			end
		end
	end

endmodule

// ===== rtl/tss_texel_fetch.sv =====
`timescale 1ns / 1ps

module tss_texel_fetch (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid_s1,
	input tss_pkg::s1_t s1,
	output logic valid_s2,
	output tss_pkg::s2_t s2,
	output logic [31:0] texel_s2
);
	import tss_pkg::*;

	logic [31:0] mem [TEXTURE_WORDS];

	always_ff @(posedge clk) begin
		if (en && valid_s1 && s1.in_range) begin
			if (s1.load) begin
				mem[s1.addr[TEX_AW-1:0]] <= s1.wdata;
			end else begin
				texel_s2 <= mem[s1.addr[TEX_AW-1:0]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && !s1.load;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2.in_range <= s1.in_range;
			s2.pixel_address <= s1.pixel_address;
			s2.shade <= s1.shade;
			s2.transparent <= s1.transparent;
			s2.last <= s1.last;
		end
	end

endmodule

// ===== rtl/tss_shader.sv =====
`timescale 1ns / 1ps

module tss_shader (
	input logic clk,
	input logic arst_n,
	input logic valid_s2,
	input tss_pkg::s2_t s2,
	input logic [31:0] texel_s2,
	output logic en,
	tss_pix_if.source pixel
);
	import tss_pkg::*;

	logic valid_s3;
	pix_t pix_s3;
	logic [31:0] texel;
	logic [31:0] color;
	logic [15:0] prod [4];

	assign en = !valid_s3 || pixel.ready;
	assign pixel.valid = valid_s3;
	assign pixel.data = pix_s3;
	assign texel = s2.in_range ? texel_s2 : 32'd0;

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			prod[ch] = {8'h00, texel[ch*8 +: 8]} * {8'h00, s2.shade};
			color[ch*8 +: 8] = prod[ch][15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s3.pixel_address <= s2.pixel_address;
			pix_s3.color <= color;
			pix_s3.write_enable <= !(s2.transparent && (texel == 32'd0));
			pix_s3.last <= s2.last;
		end
	end

endmodule
